/* rtl/char_lcd_frame_diff_writer_macros.svh */
// ============================================================================
// Character LCD frame diff writer assertion macros
// Shared concurrent assertion forms used by the RTL modules of the block.
// ============================================================================
`ifndef CHAR_LCD_FRAME_DIFF_WRITER_MACROS_SVH
`define CHAR_LCD_FRAME_DIFF_WRITER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CLFDW_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CLFDW_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/clfdw_pkg.sv */
`default_nettype none
// ============================================================================
// Character LCD frame diff writer package
// Geometry constants, command and action codes, and the shared payload types.
// ============================================================================
package clfdw_pkg;

    localparam int ROWS   = 4;
    localparam int COLS   = 20;
    localparam int CELLS  = ROWS * COLS;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] BLANK_RESET = 8'h20;

    localparam logic ACT_CELL   = 1'b0;
    localparam logic ACT_REDRAW = 1'b1;

    localparam logic CMD_CURSOR = 1'b0;
    localparam logic CMD_WRITE  = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] char_code;
    } in_t;

    typedef struct packed {
        logic       cmd_kind;
        logic [1:0] cursor_row;
        logic [4:0] cursor_col;
        logic [7:0] out_char;
        logic       last_of_run;
    } out_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [7:0]       char_code;
        logic             need_cursor;
    } q_entry_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

endpackage
`default_nettype wire

/* rtl/clfdw_front.sv */
`default_nettype none
// ============================================================================
// Character LCD frame diff writer front end
// Tracks the cell position, reads and updates the shadow frame, and queues
// one classified entry for every changed cell.
// ============================================================================
`include "char_lcd_frame_diff_writer_macros.svh"

module clfdw_front import clfdw_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_t       s_data,
    input  wire logic [7:0] blank_code,
    input  wire q_status_t q_status,
    output logic           q_push,
    output q_entry_t       q_push_data
);

    logic [7:0]       shadow_mem [CELLS];
    logic [CELLS-1:0] shadow_valid_reg, shadow_valid_next;
    logic [7:0]       rd_data_reg;

    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [CELL_W-1:0] cell_reg, cell_next;
    logic              left_changed_reg, left_changed_next;

    logic              s2_valid_reg, s2_valid_next;
    logic              s2_action_reg;
    logic [7:0]        s2_char_reg;
    logic [ROW_W-1:0]  s2_row_reg;
    logic [COL_W-1:0]  s2_col_reg;
    logic [CELL_W-1:0] s2_cell_reg;
    logic              byp_reg, byp_next;
    logic [7:0]        byp_char_reg;

    logic       s_accept;
    logic       cell_accept;
    logic       s2_is_cell;
    logic       s2_done;
    logic       changed;
    logic [7:0] old_char;

    always_comb begin
        if (byp_reg) begin
            old_char = byp_char_reg;
        end else if (shadow_valid_reg[s2_cell_reg]) begin
            old_char = rd_data_reg;
        end else begin
            old_char = blank_code;
        end
        changed    = (old_char != s2_char_reg);
        s2_is_cell = s2_valid_reg && (s2_action_reg == ACT_CELL);
        q_push     = s2_is_cell && changed && !q_status.full;
        s2_done    = s2_valid_reg &&
                     ((s2_action_reg == ACT_REDRAW) || !changed || !q_status.full);
        s_ready    = !s2_valid_reg || s2_done;
        s_accept   = s_valid && s_ready;
        cell_accept = s_accept && (s_data.action == ACT_CELL);
    end

    assign q_push_data.row         = s2_row_reg;
    assign q_push_data.col         = s2_col_reg;
    assign q_push_data.char_code   = s2_char_reg;
    assign q_push_data.need_cursor = !left_changed_reg;

    always_comb begin
        row_next  = row_reg;
        col_next  = col_reg;
        cell_next = cell_reg;
        if (cell_accept) begin
            if (col_reg == COL_W'(COLS - 1)) begin
                col_next = '0;
                row_next = (row_reg == ROW_W'(ROWS - 1)) ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
            cell_next = (cell_reg == CELL_W'(CELLS - 1)) ? '0 : cell_reg + 1'b1;
        end
    end

    always_comb begin
        shadow_valid_next = shadow_valid_reg;
        left_changed_next = left_changed_reg;
        if (s2_done && (s2_action_reg == ACT_REDRAW)) begin
            shadow_valid_next = '0;
        end else if (q_push) begin
            shadow_valid_next[s2_cell_reg] = 1'b1;
        end
        if (s2_done && s2_is_cell) begin
            left_changed_next = changed && (s2_col_reg != COL_W'(COLS - 1));
        end
    end

    always_comb begin
        s2_valid_next = s2_valid_reg;
        byp_next      = byp_reg;
        if (s_ready) begin
            s2_valid_next = s_valid;
        end
        if (s_accept) begin
            byp_next = q_push && (s2_cell_reg == cell_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg          <= '0;
            col_reg          <= '0;
            cell_reg         <= '0;
            left_changed_reg <= 1'b0;
            shadow_valid_reg <= '0;
            s2_valid_reg     <= 1'b0;
            byp_reg          <= 1'b0;
        end else begin
            row_reg          <= row_next;
            col_reg          <= col_next;
            cell_reg         <= cell_next;
            left_changed_reg <= left_changed_next;
            shadow_valid_reg <= shadow_valid_next;
            s2_valid_reg     <= s2_valid_next;
            byp_reg          <= byp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s2_action_reg <= s_data.action;
            s2_char_reg   <= s_data.char_code;
            s2_row_reg    <= row_reg;
            s2_col_reg    <= col_reg;
            s2_cell_reg   <= cell_reg;
            byp_char_reg  <= s2_char_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_push) begin
            shadow_mem[s2_cell_reg] <= s2_char_reg;
        end
        if (cell_accept) begin
            rd_data_reg <= shadow_mem[cell_reg];
        end
    end

    `CLFDW_ASSERT_IMP(a_push_not_full, aclk, aresetn, q_push, !q_status.full,
        "Front end pushed into a full queue.")
    `CLFDW_ASSERT_NXT(a_redraw_clears, aclk, aresetn,
        s2_done && (s2_action_reg == ACT_REDRAW), shadow_valid_reg == '0,
        "Redraw did not clear the shadow valid bits.")

endmodule
`default_nettype wire

/* rtl/clfdw_queue.sv */
`default_nettype none
// ============================================================================
// Character LCD frame diff writer queue
// Small first-in first-out buffer between the classifying front end and the
// command back end.
// ============================================================================
`include "char_lcd_frame_diff_writer_macros.svh"

module clfdw_queue import clfdw_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire q_entry_t push_data,
    input  wire logic     pop,
    output q_status_t     status,
    output q_entry_t      head
);

    q_entry_t            entries [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign status.not_empty = (count_reg != '0);
    assign status.full      = (count_reg == QCNT_W'(QDEPTH));
    assign head             = entries[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    `CLFDW_ASSERT_IMP(a_pop_not_empty, aclk, aresetn, pop, status.not_empty,
        "Queue popped while empty.")
    `CLFDW_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1,
        count_reg <= QCNT_W'(QDEPTH), "Queue count exceeds its depth.")

endmodule
`default_nettype wire

/* rtl/clfdw_back.sv */
`default_nettype none
// ============================================================================
// Character LCD frame diff writer back end
// Expands each queued entry into an optional set-cursor command followed by
// a write-character command, through a registered output stage.
// ============================================================================
`include "char_lcd_frame_diff_writer_macros.svh"

module clfdw_back import clfdw_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire q_status_t q_status,
    input  wire q_entry_t  q_head,
    output logic           q_pop,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_t           m_data
);

    logic m_valid_reg, m_valid_next;
    out_t m_data_reg, m_data_next;
    logic phase_reg, phase_next;

    logic slot_free;
    logic issue;
    logic send_cursor;

    always_comb begin
        slot_free   = !m_valid_reg || m_ready;
        issue       = slot_free && q_status.not_empty;
        send_cursor = q_head.need_cursor && !phase_reg;
        q_pop       = issue && !send_cursor;

        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        phase_next   = phase_reg;
        if (issue) begin
            m_valid_next           = 1'b1;
            phase_next             = send_cursor;
            m_data_next.cursor_row = 2'(q_head.row);
            m_data_next.cursor_col = 5'(q_head.col);
            if (send_cursor) begin
                m_data_next.cmd_kind    = CMD_CURSOR;
                m_data_next.out_char    = 8'h00;
                m_data_next.last_of_run = 1'b0;
            end else begin
                m_data_next.cmd_kind    = CMD_WRITE;
                m_data_next.out_char    = q_head.char_code;
                m_data_next.last_of_run = 1'b1;
            end
        end else if (slot_free) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            phase_reg   <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            phase_reg   <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `CLFDW_ASSERT_IMP(a_cursor_then_write, aclk, aresetn,
        m_valid_reg && (m_data_reg.cmd_kind == CMD_CURSOR), phase_reg,
        "Set-cursor command shown without a pending write.")
    `CLFDW_ASSERT_IMP(a_pending_entry, aclk, aresetn, phase_reg, q_status.not_empty,
        "Pending write lost its queue entry.")

endmodule
`default_nettype wire

/* rtl/char_lcd_frame_diff_writer.sv */
`default_nettype none
// ============================================================================
// Character LCD frame diff writer
// Compares each new frame cell with a shadow frame and emits cursor and
// write commands only for cells that changed.
// ============================================================================
// The block takes one cell per cycle in row-major order, or a redraw that
// marks the whole shadow frame blank, and keeps the cell position itself.
// An unchanged cell gives nothing; a changed cell gives a write command,
// preceded by a set-cursor command when it starts a run of changed cells.
// Each input transaction passes through the two-stage front end (shadow read,
// then compare and update), and the command output delivers one command per
// cycle while it has queued entries and m_ready is high, so a run of N changed
// cells gives N + 1 commands. A four-entry queue between front end and command
// output absorbs short bursts; when it fills, the input stalls until the output
// drains. Configuration writes to the blank code are taken on any cycle.
// ============================================================================

module char_lcd_frame_diff_writer import clfdw_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_t        s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_t            m_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data
);

    logic [7:0] blank_code_reg, blank_code_next;

    q_status_t q_status;
    q_entry_t  q_push_data;
    q_entry_t  q_head;
    logic      q_push;
    logic      q_pop;

    assign cfg_ready = 1'b1;

    always_comb begin
        blank_code_next = blank_code_reg;
        if (cfg_valid && cfg_ready) begin
            blank_code_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blank_code_reg <= BLANK_RESET;
        end else begin
            blank_code_reg <= blank_code_next;
        end
    end

    clfdw_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .blank_code  (blank_code_reg),
        .q_status    (q_status),
        .q_push      (q_push),
        .q_push_data (q_push_data)
    );

    clfdw_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .status    (q_status),
        .head      (q_head)
    );

    clfdw_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
`default_nettype wire

/* tb/sv/char_lcd_frame_diff_writer_test.sv */
`timescale 1ns / 100ps
// ============================================================================
// Character LCD frame diff writer testbench
// Drives frame cells and redraws into the block and checks every cursor and
// write command it emits against an independent shadow-frame predictor or, for
// typed rows, the table's expected commands. A short table of directed cells
// comes first, then random frames with many unchanged cells, under several
// blank codes and with random idling on both the input and the command output.
// ============================================================================

module char_lcd_frame_diff_writer_test;
    import clfdw_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 156;

    typedef enum int {PACE_BURST, PACE_SLOW, PACE_MIXED} pace_t;

    typedef struct {
        in_t  item;
        bit   typed;
        int   n;
        out_t c0;
        out_t c1;
    } dir_row_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_t        s_data;
    logic       m_valid;
    logic       m_ready;
    out_t       m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    logic [7:0] shadow_char [CELLS];
    logic       shadow_set [CELLS];
    int         cur_row;
    int         cur_col;
    logic       prev_changed;
    logic [7:0] blank_char;

    out_t       cmd_expect_q [$];
    dir_row_t   dir_table [$];
    out_t       exp_cmd;
    int         errors;
    int         cycles;
    int         items_sent;
    int         redraws_sent;
    int         cmds_checked;
    int         blank_writes;
    pace_t      send_pace;
    pace_t      recv_pace;

    char_lcd_frame_diff_writer u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int draw_wait(input pace_t pace);
        case (pace)
            PACE_BURST: return 0;
            PACE_SLOW:  return $urandom_range(0, 18);
            default:    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
        endcase
    endfunction

    function automatic out_t lcd_cmd(input logic kind, input logic [1:0] row,
                                     input logic [4:0] col, input logic [7:0] ch,
                                     input logic last);
        out_t c;
        c.cmd_kind    = kind;
        c.cursor_row  = row;
        c.cursor_col  = col;
        c.out_char    = ch;
        c.last_of_run = last;
        return c;
    endfunction

    // Steps the shadow frame by one transaction and returns the commands it causes.
    function automatic int predict_cell(input in_t item, output out_t c0, output out_t c1);
        int         cell_idx;
        logic [7:0] old;
        logic       changed;
        out_t       wr;
        int         n;
        c0 = '0;
        c1 = '0;
        n  = 0;
        if (item.action == ACT_REDRAW) begin
            foreach (shadow_set[i]) shadow_set[i] = 1'b0;
            return 0;
        end
        cell_idx = cur_row * COLS + cur_col;
        old      = shadow_set[cell_idx] ? shadow_char[cell_idx] : blank_char;
        changed  = (old != item.char_code);
        if (changed) begin
            wr = lcd_cmd(CMD_WRITE, 2'(cur_row), 5'(cur_col), item.char_code, 1'b1);
            if (!prev_changed) begin
                c0 = lcd_cmd(CMD_CURSOR, 2'(cur_row), 5'(cur_col), 8'h00, 1'b0);
                c1 = wr;
                n  = 2;
            end else begin
                c0 = wr;
                n  = 1;
            end
            shadow_char[cell_idx] = item.char_code;
            shadow_set[cell_idx]  = 1'b1;
        end
        prev_changed = changed;
        cur_col++;
        if (cur_col >= COLS) begin
            cur_col      = 0;
            prev_changed = 1'b0;
            cur_row++;
            if (cur_row >= ROWS) cur_row = 0;
        end
        return n;
    endfunction

    // Many cells repeat the shown character so that runs of changes stay short.
    function automatic in_t random_cell();
        in_t        item;
        int         pick;
        logic [7:0] old;
        pick = $urandom_range(0, 99);
        item.char_code = 8'($urandom_range(0, 255));
        if (pick < 3) begin
            item.action = ACT_REDRAW;
        end else begin
            item.action = ACT_CELL;
            old = shadow_set[cur_row * COLS + cur_col] ?
                  shadow_char[cur_row * COLS + cur_col] : blank_char;
            if (pick < 45) item.char_code = old;
            else if (pick < 60) item.char_code = blank_char;
        end
        return item;
    endfunction

    task automatic add_row(input logic action, input logic [7:0] ch, input bit typed,
                           input int n, input out_t c0, input out_t c1);
        dir_row_t r;
        r.item.action    = action;
        r.item.char_code = ch;
        r.typed          = typed;
        r.n              = n;
        r.c0             = c0;
        r.c1             = c1;
        dir_table = {dir_table, r};
    endtask

    task automatic send_item(input in_t item, input bit typed, input int n_typed,
                             input out_t t0, input out_t t1);
        int   gap;
        int   n;
        out_t c0;
        out_t c1;
        gap = draw_wait(send_pace);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        n = predict_cell(item, c0, c1);
        if (typed) begin
            n  = n_typed;
            c0 = t0;
            c1 = t1;
        end
        if (n > 0) cmd_expect_q = {cmd_expect_q, c0};
        if (n > 1) cmd_expect_q = {cmd_expect_q, c1};
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (item.action == ACT_REDRAW) redraws_sent++;
        if (items_sent % 40 == 0) send_pace = pace_t'($urandom_range(0, 2));
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (cmd_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_blank(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        blank_char = value;
        blank_writes++;
    endtask

    task automatic check_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                     expected, actual);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            cmds_checked++;
            if (cmd_expect_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected command, expected none, actual %h", $time, m_data);
            end else begin
                exp_cmd = cmd_expect_q.pop_front();
                check_field("cmd_kind", exp_cmd.cmd_kind, m_data.cmd_kind);
                check_field("cursor_row", exp_cmd.cursor_row, m_data.cursor_row);
                check_field("cursor_col", exp_cmd.cursor_col, m_data.cursor_col);
                check_field("out_char", exp_cmd.out_char, m_data.out_char);
                check_field("last_of_run", exp_cmd.last_of_run, m_data.last_of_run);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d commands outstanding", $time, cmd_expect_q.size());
            $display("char_lcd_frame_diff_writer_test: done, errors");
            $finish;
        end
    end

    initial begin
        int stall;
        int taken;
        m_ready   = 1'b0;
        recv_pace = PACE_MIXED;
        taken     = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = draw_wait(recv_pace);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            taken++;
            if (taken % 40 == 0) recv_pace = pace_t'($urandom_range(0, 2));
        end
    end

    initial begin
        logic [7:0] blank_plan [4];
        out_t       none;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        cfg_valid    = 1'b0;
        cfg_data     = 8'h00;
        errors       = 0;
        cycles       = 0;
        items_sent   = 0;
        redraws_sent = 0;
        cmds_checked = 0;
        blank_writes = 0;
        cur_row      = 0;
        cur_col      = 0;
        prev_changed = 1'b0;
        blank_char   = BLANK_RESET;
        send_pace    = PACE_MIXED;
        none         = '0;
        foreach (shadow_set[i]) begin
            shadow_set[i]  = 1'b0;
            shadow_char[i] = 8'h00;
        end

        add_row(ACT_CELL, 8'h20, 1'b1, 0, none, none);
        add_row(ACT_CELL, 8'h00, 1'b1, 2, lcd_cmd(CMD_CURSOR, 2'd0, 5'd1, 8'h00, 1'b0),
                lcd_cmd(CMD_WRITE, 2'd0, 5'd1, 8'h00, 1'b1));
        add_row(ACT_CELL, 8'hFF, 1'b1, 1, lcd_cmd(CMD_WRITE, 2'd0, 5'd2, 8'hFF, 1'b1), none);
        add_row(ACT_CELL, 8'h20, 1'b1, 0, none, none);
        add_row(ACT_CELL, 8'h80, 1'b1, 2, lcd_cmd(CMD_CURSOR, 2'd0, 5'd4, 8'h00, 1'b0),
                lcd_cmd(CMD_WRITE, 2'd0, 5'd4, 8'h80, 1'b1));
        add_row(ACT_REDRAW, 8'hFF, 1'b1, 0, none, none);
        add_row(ACT_CELL, 8'h7F, 1'b1, 1, lcd_cmd(CMD_WRITE, 2'd0, 5'd5, 8'h7F, 1'b1), none);
        add_row(ACT_CELL, 8'h55, 1'b1, 1, lcd_cmd(CMD_WRITE, 2'd0, 5'd6, 8'h55, 1'b1), none);
        add_row(ACT_CELL, 8'hAA, 1'b1, 1, lcd_cmd(CMD_WRITE, 2'd0, 5'd7, 8'hAA, 1'b1), none);
        for (int c = 8; c < 17; c++) add_row(ACT_CELL, 8'h20, 1'b0, 0, none, none);
        add_row(ACT_CELL, 8'h41, 1'b0, 0, none, none);
        add_row(ACT_CELL, 8'h42, 1'b0, 0, none, none);
        add_row(ACT_CELL, 8'h43, 1'b0, 0, none, none);
        add_row(ACT_CELL, 8'h31, 1'b0, 0, none, none);
        add_row(ACT_CELL, 8'h20, 1'b0, 0, none, none);
        add_row(ACT_REDRAW, 8'h00, 1'b0, 0, none, none);
        add_row(ACT_CELL, 8'h20, 1'b0, 0, none, none);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_table[i])
            send_item(dir_table[i].item, dir_table[i].typed, dir_table[i].n,
                      dir_table[i].c0, dir_table[i].c1);
        settle();

        blank_plan[0] = 8'h00;
        blank_plan[1] = 8'hFF;
        blank_plan[2] = 8'($urandom_range(1, 254));
        blank_plan[3] = BLANK_RESET;
        foreach (blank_plan[p]) begin
            write_blank(blank_plan[p]);
            repeat (PHASE_ITEMS) send_item(random_cell(), 1'b0, 0, none, none);
            settle();
        end

        repeat (20) @(posedge aclk);
        if (cmd_expect_q.size() != 0) begin
            errors++;
            $display("%0t: %0d expected commands never arrived", $time, cmd_expect_q.size());
        end
        $display("Sent %0d transactions (%0d redraws) under %0d blank codes.",
                 items_sent, redraws_sent, blank_writes + 1);
        $display("Checked %0d commands, %0d mismatches.", cmds_checked, errors);
        if (errors == 0) begin
            $display("char_lcd_frame_diff_writer_test: done, clean");
        end else begin
            $display("char_lcd_frame_diff_writer_test: done, errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/clfdw_pkg.sv
rtl/clfdw_front.sv
rtl/clfdw_queue.sv
rtl/clfdw_back.sv
rtl/char_lcd_frame_diff_writer.sv
tb/sv/char_lcd_frame_diff_writer_test.sv
